### rtl/core/tafl_pkg.sv
// Shared types, codes and constants for the tracker advertisement filter.
// Used by every module of the block but tafl_ram; depends on nothing else.
`default_nettype none

package tafl_pkg;

    // Table size and the longest payload that is parsed.
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_PAYLOAD_DEF   = 31;

    // Report interval after reset.
    localparam logic [31:0] INTERVAL_RESET = 32'd5000;

    // Configuration port.
    localparam int          CFG_ADDR_W   = 3;
    localparam logic        CFG_IDX_INTERVAL = 1'b0;

    // Request action codes.
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Manufacturer data header that marks a tracker advertisement.
    localparam logic [7:0] AD_TYPE_MFG  = 8'hFF;
    localparam logic [7:0] COMPANY_LO   = 8'h4C;
    localparam logic [7:0] COMPANY_HI   = 8'h00;
    localparam logic [7:0] MSG_TYPE     = 8'h12;
    localparam logic [2:0] HDR_LEN      = 3'd4;
    localparam logic [2:0] HDR_FAILED   = 3'd7;

    // Queue between the parser and the table engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         adv_byte;
        logic               last_byte;
        logic [47:0]        sender_address;
        logic signed [7:0]  signal_dbm;
        logic [31:0]        now_tick;
        logic [5:0]         entry_select;
    } t_req;

    typedef struct packed {
        logic               match_found;
        logic [5:0]         entry_index;
        logic               is_new_entry;
        logic               table_full_drop;
        logic               report_due;
        logic [6:0]         entry_count;
        logic               read_ok;
        logic [47:0]        read_address;
        logic signed [7:0]  read_signal_dbm;
    } t_res;

    typedef enum logic [1:0] {
        OP_EVAL,
        OP_START,
        OP_STOP,
        OP_READ
    } t_op;

    // One classified request, handed from the parser to the table engine.
    typedef struct packed {
        t_op                op;
        logic               matched;
        logic [47:0]        addr;
        logic signed [7:0]  sig;
        logic [31:0]        now;
        logic [5:0]         sel;
    } t_job;

    typedef struct packed {
        logic [47:0]        addr;
        logic signed [7:0]  sig;
        logic [31:0]        tick;
    } t_entry;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_CMP,
        BS_UPD,
        BS_READ
    } t_bstate;

    // Expected header byte at a given offset into a structure, offset 1 first.
    function automatic logic [7:0] hdr_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = AD_TYPE_MFG;
            2'd1:    b = COMPANY_LO;
            2'd2:    b = COMPANY_HI;
            default: b = MSG_TYPE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/tafl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module tafl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/tafl_front.sv
// Front end: walks the AD structures byte by byte and classifies requests.
// Depends on tafl_pkg; feeds tafl_queue.
`default_nettype none

module tafl_front #(
    parameter int MAX_PAYLOAD = tafl_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire tafl_pkg::t_req i_req,
    output logic               o_push,
    output tafl_pkg::t_job     o_job
);

    localparam logic [7:0] MAX_POS = 8'(MAX_PAYLOAD);

    logic [7:0] r_pos,    n_pos;
    logic [8:0] r_sstart, n_sstart;
    logic [7:0] r_slen,   n_slen;
    logic       r_halt,   n_halt;
    logic [2:0] r_hdr,    n_hdr;
    logic [8:0] r_cend,   n_cend;
    logic       r_cseen,  n_cseen;

    logic [8:0] off;
    logic [8:0] off_m1;
    logic       is_byte;
    logic       matched;

    always_comb begin
        n_pos    = r_pos;
        n_sstart = r_sstart;
        n_slen   = r_slen;
        n_halt   = r_halt;
        n_hdr    = r_hdr;
        n_cend   = r_cend;
        n_cseen  = r_cseen;
        off      = {1'b0, r_pos} + {1'b0, r_slen} + 9'd1 - r_sstart;
        off_m1   = off - 9'd1;
        is_byte  = (i_req.action == tafl_pkg::ACT_BYTE);

        // Bytes past the payload limit are counted as nothing.
        if (i_accept && is_byte && (r_pos < MAX_POS)) begin
            n_pos = r_pos + 8'd1;
            if (!r_halt && !r_cseen) begin
                if ({1'b0, r_pos} == r_sstart) begin
                    // Length byte of a new structure; zero ends the walk.
                    if (i_req.adv_byte == 8'd0) begin
                        n_halt = 1'b1;
                    end else begin
                        n_slen   = i_req.adv_byte;
                        n_sstart = {1'b0, r_pos} + 9'd1 + {1'b0, i_req.adv_byte};
                        n_hdr    = 3'd0;
                    end
                end else if ((r_hdr != tafl_pkg::HDR_FAILED) && (off <= 9'd4)) begin
                    if ((off == {6'd0, r_hdr} + 9'd1) &&
                        (i_req.adv_byte == tafl_pkg::hdr_byte(off_m1[1:0]))) begin
                        n_hdr = off[2:0];
                        if ((off[2:0] == tafl_pkg::HDR_LEN) && (r_slen >= 8'd4)) begin
                            n_cseen = 1'b1;
                            n_cend  = r_sstart;
                        end
                    end else begin
                        n_hdr = tafl_pkg::HDR_FAILED;
                    end
                end
            end
        end

        // The candidate counts only if it ends within the received payload.
        matched = (n_pos >= 8'd4) && n_cseen && (n_cend <= {1'b0, n_pos});

        o_push       = 1'b0;
        o_job.op     = tafl_pkg::OP_EVAL;
        o_job.matched = matched;
        o_job.addr   = i_req.sender_address;
        o_job.sig    = i_req.signal_dbm;
        o_job.now    = i_req.now_tick;
        o_job.sel    = i_req.entry_select;

        if (i_accept) begin
            case (i_req.action)
                tafl_pkg::ACT_BYTE: begin
                    if (i_req.last_byte) begin
                        o_push   = 1'b1;
                        n_pos    = 8'd0;
                        n_sstart = 9'd0;
                        n_slen   = 8'd0;
                        n_halt   = 1'b0;
                        n_hdr    = 3'd0;
                        n_cend   = 9'd0;
                        n_cseen  = 1'b0;
                    end
                end
                tafl_pkg::ACT_START: begin
                    o_push   = 1'b1;
                    o_job.op = tafl_pkg::OP_START;
                end
                tafl_pkg::ACT_STOP: begin
                    o_push   = 1'b1;
                    o_job.op = tafl_pkg::OP_STOP;
                end
                default: begin
                    o_push   = 1'b1;
                    o_job.op = tafl_pkg::OP_READ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_sstart <= 9'd0;
            r_slen   <= 8'd0;
            r_halt   <= 1'b0;
            r_hdr    <= 3'd0;
            r_cend   <= 9'd0;
            r_cseen  <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_sstart <= n_sstart;
            r_slen   <= n_slen;
            r_halt   <= n_halt;
            r_hdr    <= n_hdr;
            r_cend   <= n_cend;
            r_cseen  <= n_cseen;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tafl_queue.sv
// Two-entry queue of classified requests between the front and back ends.
// Depends on tafl_pkg for the request type and depth.
`default_nettype none

module tafl_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tafl_pkg::t_job i_job,
    input  wire logic           i_pop,
    output tafl_pkg::t_job      o_head,
    output logic                o_full,
    output logic                o_empty
);

    tafl_pkg::t_job              r_mem [tafl_pkg::Q_DEPTH];
    logic [tafl_pkg::Q_PTR_W-1:0] r_wp, r_rp;
    logic [tafl_pkg::Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == tafl_pkg::Q_CNT_W'(tafl_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/tafl_back.sv
// Back end: holds the tracked-entry table and carries out queued requests.
// Depends on tafl_pkg and instantiates tafl_ram for the table storage.
`default_nettype none

module tafl_back #(
    parameter int TABLE_ENTRIES = tafl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [31:0]    i_interval,
    input  wire logic           i_empty,
    input  wire tafl_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    output tafl_pkg::t_res      o_res
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
    localparam int EW = $bits(tafl_pkg::t_entry);

    tafl_pkg::t_bstate r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_active, n_active;
    logic [IDX_W-1:0]  r_idx, n_idx;
    tafl_pkg::t_job    r_job, n_job;
    logic              n_valid;
    tafl_pkg::t_res    n_res;

    tafl_pkg::t_job    cur;
    tafl_pkg::t_entry  rd_entry;
    tafl_pkg::t_entry  wr_entry;
    logic [EW-1:0]     ram_rdata;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic              do_miss;
    logic              due;
    logic [31:0]       elapsed;

    tafl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = tafl_pkg::t_entry'(ram_rdata);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_active = r_active;
        n_idx    = r_idx;
        n_job    = r_job;
        o_pop    = 1'b0;
        we       = 1'b0;
        waddr    = r_idx;
        wr_entry = rd_entry;
        n_valid  = 1'b0;
        n_res    = '0;
        do_miss  = 1'b0;
        cur      = (r_state == tafl_pkg::BS_IDLE) ? i_job : r_job;
        elapsed  = r_job.now - rd_entry.tick;
        due      = (rd_entry.tick == 32'd0) || (elapsed >= i_interval);

        case (r_state)
            tafl_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    case (i_job.op)
                        tafl_pkg::OP_START: begin
                            n_count  = '0;
                            n_active = 1'b1;
                            n_valid  = 1'b1;
                        end
                        tafl_pkg::OP_STOP: begin
                            n_active = 1'b0;
                            n_valid  = 1'b1;
                        end
                        tafl_pkg::OP_READ: begin
                            if ({1'b0, i_job.sel} < 7'(r_count)) begin
                                n_idx   = i_job.sel[IDX_W-1:0];
                                n_state = tafl_pkg::BS_READ;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            if (!(i_job.matched && r_active)) begin
                                n_valid = 1'b1;
                            end else if (r_count == '0) begin
                                do_miss = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = tafl_pkg::BS_CMP;
                            end
                        end
                    endcase
                end
            end
            tafl_pkg::BS_CMP: begin
                if (rd_entry.addr == r_job.addr) begin
                    n_state = tafl_pkg::BS_UPD;
                end else if (7'(r_idx) + 7'd1 == 7'(r_count)) begin
                    do_miss = 1'b1;
                    n_state = tafl_pkg::BS_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tafl_pkg::BS_UPD: begin
                // Known sender: refresh its signal and restamp when a report is due.
                we            = 1'b1;
                wr_entry.addr = r_job.addr;
                wr_entry.sig  = r_job.sig;
                wr_entry.tick = due ? r_job.now : rd_entry.tick;
                n_valid             = 1'b1;
                n_res.match_found   = 1'b1;
                n_res.entry_index   = 6'(r_idx);
                n_res.report_due    = due;
                n_state             = tafl_pkg::BS_IDLE;
            end
            tafl_pkg::BS_READ: begin
                n_valid               = 1'b1;
                n_res.read_ok         = 1'b1;
                n_res.read_address    = rd_entry.addr;
                n_res.read_signal_dbm = rd_entry.sig;
                n_state               = tafl_pkg::BS_IDLE;
            end
            default: begin
                n_state = tafl_pkg::BS_IDLE;
            end
        endcase

        // Sender not in the table: append it, or drop it when the table is full.
        if (do_miss) begin
            n_valid           = 1'b1;
            n_res.match_found = 1'b1;
            if (r_count >= FULL_COUNT) begin
                n_res.table_full_drop = 1'b1;
            end else begin
                we                 = 1'b1;
                waddr              = r_count[IDX_W-1:0];
                wr_entry.addr      = cur.addr;
                wr_entry.sig       = cur.sig;
                wr_entry.tick      = cur.now;
                n_res.entry_index  = 6'(r_count);
                n_res.is_new_entry = 1'b1;
                n_count            = r_count + 1'b1;
            end
        end

        n_res.entry_count = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tafl_pkg::BS_IDLE;
            r_count  <= '0;
            r_active <= 1'b0;
            r_idx    <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_active <= n_active;
            r_idx    <= n_idx;
            o_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        o_res <= n_res;
    end

endmodule

`default_nettype wire

### rtl/core/tracker_adv_filter_table.sv
// Top level of the tracker advertisement filter and table.
// Depends on tafl_pkg; instantiates tafl_front, tafl_queue and tafl_back.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low. Payload bytes (action 0) are parsed by the front end in the cycle they
// arrive; only the last byte of an advertisement, and every start, stop or
// read request, yields a result. Those are classified and placed in a
// two-entry queue, so busy rises only when the queue is full.
// The back end takes one queued request at a time. Start, stop, a read that
// is out of range, a payload that does not match or arrives while the scan
// is stopped, and a match against an empty table are answered from the idle
// state; an in-range read waits for one table RAM read. Any other match walks
// the table one entry per cycle through the table RAM read port; the back
// end takes no new request until it ends, and that walk sets the throughput.
// Each result is shown on o_result for exactly one cycle with o_valid high;
// the receiver cannot stall, and results leave in request order.
// Reset empties the table, clears the scan-active flag and parser state, and
// sets the report interval to 5000 ticks. The user must write it via the APB
// port at byte address 0 and only while the block is idle; it is not enforced.
`default_nettype none

module tracker_adv_filter_table #(
    parameter int TABLE_ENTRIES = tafl_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PAYLOAD   = tafl_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire tafl_pkg::t_req                i_request,
    output logic                               o_valid,
    output tafl_pkg::t_res                     o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tafl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [31:0]    r_interval;
    logic           accept;
    logic           push;
    logic           pop;
    logic           q_empty;
    tafl_pkg::t_job push_job;
    tafl_pkg::t_job head_job;

    // Configuration register: the only register sits in the lowest word.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tafl_pkg::CFG_IDX_INTERVAL) ? r_interval : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= tafl_pkg::INTERVAL_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == tafl_pkg::CFG_IDX_INTERVAL)) begin
            r_interval <= pwdata;
        end
    end

    assign accept = start && !busy;

    tafl_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_request),
        .o_push   (push),
        .o_job    (push_job)
    );

    // The queue lets the parser keep taking bytes while the table is searched.
    tafl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (busy),
        .o_empty (q_empty)
    );

    tafl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_interval (r_interval),
        .i_empty    (q_empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_res      (o_result)
    );

endmodule

`default_nettype wire

### tb/sv/tracker_adv_filter_table_chk.sv
// Checker for tracker_adv_filter_table: predicts every result from accepted requests
// and APB writes, and compares each result field by field. Depends on tafl_pkg.
module tracker_adv_filter_table_chk
    import tafl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_req                  i_request,
    input  logic                  i_valid,
    input  t_res                  i_result,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [CFG_ADDR_W-1:0] INTERVAL_ADDR = CFG_ADDR_W'(4 * CFG_IDX_INTERVAL);
    localparam logic [7:0] TRACKER_HDR [4] = '{AD_TYPE_MFG, COMPANY_LO, COMPANY_HI, MSG_TYPE};

    // Tracked senders and scan state.
    logic [47:0]        trk_addr [TABLE_ENTRIES];
    logic signed [7:0]  trk_sig  [TABLE_ENTRIES];
    logic [31:0]        trk_tick [TABLE_ENTRIES];
    int unsigned        trk_count;
    bit                 scanning;
    logic [31:0]        interval;

    // Walk through the AD structures of the payload in flight.
    int unsigned        pos;
    int unsigned        seg_start;
    int unsigned        seg_len;
    int unsigned        hdr_prog;
    int unsigned        cand_end;
    bit                 halted;
    bit                 cand_seen;

    t_res               outcome_q [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic report_miss(input string msg);
        $display("%0t chk: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want) begin
            report_miss($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    function automatic void clear_parse();
        pos = 0;
        seg_start = 0;
        seg_len = 0;
        hdr_prog = 0;
        cand_end = 0;
        halted = 1'b0;
        cand_seen = 1'b0;
    endfunction

    function automatic void walk_byte(input logic [7:0] b);
        int unsigned off;
        if (halted || cand_seen) return;
        if (pos == seg_start) begin
            if (b == 8'd0) begin
                halted = 1'b1;
                return;
            end
            seg_len = b;
            seg_start = pos + 1 + b;
            hdr_prog = 0;
            return;
        end
        off = pos + seg_len + 1 - seg_start;
        if (hdr_prog == HDR_FAILED || off > HDR_LEN) return;
        if (off == hdr_prog + 1 && b == TRACKER_HDR[off-1]) begin
            hdr_prog = off;
            if (off == HDR_LEN && seg_len >= HDR_LEN) begin
                cand_seen = 1'b1;
                cand_end = seg_start;
            end
        end else begin
            hdr_prog = HDR_FAILED;
        end
    endfunction

    // Applies one accepted request; returns 1 with the result when it produces one.
    function automatic bit track_step(input t_req rq, output t_res res);
        int unsigned len;
        int unsigned idx;
        bit          hit;
        bit          found;
        logic [31:0] elapsed;
        res = '0;
        case (rq.action)
            ACT_BYTE: begin
                if (pos < MAX_PAYLOAD) begin
                    walk_byte(rq.adv_byte);
                    pos++;
                end
                if (!rq.last_byte) return 1'b0;
                len = pos;
                hit = len >= HDR_LEN && cand_seen && cand_end <= len;
                clear_parse();
                if (hit && scanning) begin
                    res.match_found = 1'b1;
                    found = 1'b0;
                    idx = 0;
                    for (int i = 0; i < trk_count; i++) begin
                        if (!found && trk_addr[i] == rq.sender_address) begin
                            found = 1'b1;
                            idx = i;
                        end
                    end
                    if (found) begin
                        trk_sig[idx] = rq.signal_dbm;
                        res.entry_index = idx[5:0];
                        elapsed = rq.now_tick - trk_tick[idx];
                        if (trk_tick[idx] == 32'd0 || elapsed >= interval) begin
                            res.report_due = 1'b1;
                            trk_tick[idx] = rq.now_tick;
                        end
                    end else if (trk_count >= TABLE_ENTRIES) begin
                        res.table_full_drop = 1'b1;
                    end else begin
                        trk_addr[trk_count] = rq.sender_address;
                        trk_sig[trk_count] = rq.signal_dbm;
                        trk_tick[trk_count] = rq.now_tick;
                        res.entry_index = trk_count[5:0];
                        res.is_new_entry = 1'b1;
                        trk_count++;
                    end
                end
            end
            ACT_START: begin
                trk_count = 0;
                scanning = 1'b1;
            end
            ACT_STOP: begin
                scanning = 1'b0;
            end
            default: begin
                if (rq.entry_select < trk_count) begin
                    res.read_ok = 1'b1;
                    res.read_address = trk_addr[rq.entry_select];
                    res.read_signal_dbm = trk_sig[rq.entry_select];
                end
            end
        endcase
        res.entry_count = trk_count[6:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        t_res fresh;
        if (!i_rst_n) begin
            trk_count = 0;
            scanning = 1'b0;
            interval = INTERVAL_RESET;
            clear_parse();
            outcome_q.delete();
        end else begin
            // A result is registered by the back end after its request has passed the
            // queue, so the comparison goes before this edge's request is predicted.
            if (i_valid === 1'b1) begin
                if (outcome_q.size() == 0) begin
                    report_miss("result with no request awaiting one");
                end else begin
                    want = outcome_q.pop_front();
                    cmp_field("match_found", i_result.match_found, want.match_found);
                    cmp_field("entry_index", i_result.entry_index, want.entry_index);
                    cmp_field("is_new_entry", i_result.is_new_entry, want.is_new_entry);
                    cmp_field("table_full_drop", i_result.table_full_drop,
                              want.table_full_drop);
                    cmp_field("report_due", i_result.report_due, want.report_due);
                    cmp_field("entry_count", i_result.entry_count, want.entry_count);
                    cmp_field("read_ok", i_result.read_ok, want.read_ok);
                    cmp_field("read_address", i_result.read_address, want.read_address);
                    cmp_field("read_signal_dbm", i_result.read_signal_dbm,
                              want.read_signal_dbm);
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                if (track_step(i_request, fresh)) outcome_q.push_back(fresh);
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == INTERVAL_ADDR) begin
                interval = i_pwdata;
            end
        end
        o_pending <= outcome_q.size();
    end

endmodule

### tb/sv/tracker_adv_filter_table_tb.sv
// Testbench top for tracker_adv_filter_table: drives requests and APB writes,
// and gives the verdict. Depends on tafl_pkg and tracker_adv_filter_table_chk.
module tracker_adv_filter_table_tb;
    import tafl_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] INTERVAL_ADDR = CFG_ADDR_W'(4 * CFG_IDX_INTERVAL);
    // One word past the only register; writes there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = CFG_ADDR_W'(4 * (CFG_IDX_INTERVAL + 1));
    localparam int POOL_SIZE = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_request = '0;
    logic                  o_valid;
    t_res                  o_result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;

    // Stimulus state: the percentage of cycles in which the sender idles, the
    // count of accepted requests, a running tick and a pool of recurring senders.
    int                    gap_pct = 0;
    int                    sent = 0;
    logic [31:0]           clock_tick = 32'd1;
    logic [47:0]           sender_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    tracker_adv_filter_table uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tracker_adv_filter_table_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_request    (i_request),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // A request with every field random. Callers then set the fields that
    // matter for the action, so the unused fields still toggle every bit.
    function automatic t_req scrambled();
        t_req rq;
        rq.action         = 2'($urandom);
        rq.adv_byte       = 8'($urandom);
        rq.last_byte      = 1'($urandom);
        rq.sender_address = {16'($urandom), 32'($urandom)};
        rq.signal_dbm     = 8'($urandom);
        rq.now_tick       = $urandom;
        rq.entry_select   = 6'($urandom);
        return rq;
    endfunction

    // Every call starts and ends at a rising edge. start is held high while
    // busy pushes back; it is only lowered when a pause follows the request,
    // so back-to-back requests keep it high without a glitch. Each further
    // idle cycle is drawn with the same odds, so the sender idles in about
    // gap_pct cycles of a hundred.
    task automatic push_request(input t_req rq);
        start <= 1'b1;
        i_request <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
    endtask

    task automatic send_action(input logic [1:0] act, input logic [5:0] sel);
        t_req rq;
        rq = scrambled();
        rq.action = act;
        rq.entry_select = sel;
        push_request(rq);
    endtask

    // Sends one advertisement as a run of byte requests; the sender, signal
    // and tick only count on the last byte.
    task automatic send_bytes(input logic [7:0] bytes[$], input logic [47:0] addr,
                              input logic signed [7:0] sig, input logic [31:0] tick);
        t_req rq;
        for (int k = 0; k < bytes.size(); k++) begin
            rq = scrambled();
            rq.action = ACT_BYTE;
            rq.adv_byte = bytes[k];
            rq.last_byte = (k == bytes.size() - 1);
            if (rq.last_byte) begin
                rq.sender_address = addr;
                rq.signal_dbm = sig;
                rq.now_tick = tick;
            end
            push_request(rq);
        end
    endtask

    // Builds one advertisement. A shaped one is a chain of AD structures, about
    // half of them carrying the tracker header, with a few of those headers
    // corrupted. Some get a zero-length terminator with trailing junk, some are
    // cut short so the last structure runs past the end, and some are long
    // enough to overrun the parsed window. Noise is random bytes of random length.
    task automatic send_advert(input bit shaped);
        logic [7:0]        bytes [$];
        int                nseg;
        int                seg_len;
        int                cut;
        logic [47:0]       addr;
        logic [31:0]       tick;
        int                pick;
        if (shaped) begin
            nseg = ($urandom_range(99) < 12) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            for (int s = 0; s < nseg; s++) begin
                if ($urandom_range(1) == 1) begin
                    seg_len = $urandom_range(HDR_LEN, 10);
                    bytes.push_back(8'(seg_len));
                    bytes.push_back(AD_TYPE_MFG);
                    bytes.push_back(COMPANY_LO);
                    bytes.push_back(COMPANY_HI);
                    bytes.push_back(MSG_TYPE);
                    if ($urandom_range(99) < 10) begin
                        bytes[bytes.size() - $urandom_range(1, 4)] = 8'($urandom);
                    end
                    repeat (seg_len - HDR_LEN) bytes.push_back(8'($urandom));
                end else begin
                    seg_len = $urandom_range(1, 6);
                    bytes.push_back(8'(seg_len));
                    repeat (seg_len) bytes.push_back(8'($urandom));
                end
            end
            if ($urandom_range(99) < 15) begin
                bytes.push_back(8'd0);
                repeat ($urandom_range(0, 4)) bytes.push_back(8'($urandom));
            end
            if ($urandom_range(99) < 15 && bytes.size() > 1) begin
                cut = $urandom_range(1, (bytes.size() > 5) ? 4 : bytes.size() - 1);
                repeat (cut) void'(bytes.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 40)) bytes.push_back(8'($urandom));
        end

        // Mostly recurring senders, so that entries are found again and the
        // table fills up; now and then a fresh random one.
        addr = ($urandom_range(99) < 85) ? sender_pool[$urandom_range(POOL_SIZE - 1)]
                                         : {16'($urandom), 32'($urandom)};

        // The running tick mostly creeps forward so report intervals elapse at
        // a useful rate; sometimes it jumps anywhere, which also covers
        // wrap-around, and sometimes the advertisement carries a zero tick.
        pick = $urandom_range(99);
        if (pick < 3) begin
            clock_tick = $urandom;
        end else begin
            clock_tick = clock_tick + $urandom_range(0, 2500);
        end
        tick = (pick >= 3 && pick < 8) ? 32'd0 : clock_tick;

        send_bytes(bytes, addr, 8'($urandom), tick);
    endtask

    // One phase of random traffic: mostly shaped advertisements, the rest noise,
    // reads, and the odd start or stop to reset and pause the table.
    task automatic run_phase(input int count);
        int target;
        int pick;
        target = sent + count;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_action(ACT_START, 6'($urandom));
            end else if (pick < 7) begin
                send_action(ACT_STOP, 6'($urandom));
            end else if (pick < 17) begin
                send_action(ACT_READ, ($urandom_range(99) < 75) ? 6'($urandom_range(0, 15))
                                                                : 6'($urandom));
            end else if (pick < 82) begin
                send_advert(1'b1);
            end else begin
                send_advert(1'b0);
            end
        end
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every predicted result has come back, then lets the longest
    // table walk run out in case a request with no result is still inside.
    // The pending count is registered and lags behind, hence the first edge.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES_DEF + 8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0] tracker_ad [$];
        logic [7:0] cut_ad [$];
        logic [47:0] first_sender;

        for (int i = 0; i < POOL_SIZE; i++) begin
            sender_pool[i] = {16'($urandom), 32'($urandom)};
        end
        sender_pool[0] = '1;
        sender_pool[1] = '0;
        first_sender = sender_pool[0];

        // Shortest matching advertisement, and one whose tracker structure
        // claims two bytes more than the payload holds.
        tracker_ad = '{8'd4, AD_TYPE_MFG, COMPANY_LO, COMPANY_HI, MSG_TYPE};
        cut_ad = '{8'd6, AD_TYPE_MFG, COMPANY_LO, COMPANY_HI, MSG_TYPE};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset interval and without pauses: a read of
        // the empty table, a match while the scan is stopped, then a new entry,
        // a repeat of it with a zero stored tick so a report is due, a
        // truncated tracker structure, reads at both ends of the index range,
        // and a stop.
        send_action(ACT_READ, 6'd0);
        send_bytes(tracker_ad, first_sender, 8'sd5, 32'd100);
        send_action(ACT_START, 6'd0);
        send_bytes(tracker_ad, first_sender, -8'sd128, 32'd0);
        send_bytes(tracker_ad, first_sender, 8'sd127, 32'd0);
        send_bytes(cut_ad, sender_pool[1], 8'sd0, 32'hFFFF_FFFF);
        send_action(ACT_READ, 6'd0);
        send_action(ACT_READ, 6'd63);
        send_action(ACT_STOP, 6'd0);
        settle();

        // Zero interval: every repeat sighting reports. The stray write to the
        // unmapped address must leave the interval alone.
        apb_write(UNMAPPED_ADDR, 32'd7);
        apb_write(INTERVAL_ADDR, 32'd0);
        gap_pct = 22;
        run_phase(540);
        settle();

        // Largest interval: reports only from a zero tick or an exact wrap.
        apb_write(INTERVAL_ADDR, 32'hFFFF_FFFF);
        gap_pct = 48;
        run_phase(540);
        settle();

        // A middling interval comparable with the tick steps, at full rate.
        apb_write(INTERVAL_ADDR, $urandom_range(1, 8000));
        gap_pct = 0;
        run_phase(540);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("tracker_adv_filter_table_tb passed");
        end else begin
            $display("tracker_adv_filter_table_tb failed");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin : watchdog
        #3000000;
        $display("tracker_adv_filter_table_tb failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/tafl_pkg.sv
rtl/core/tafl_ram.sv
rtl/core/tafl_front.sv
rtl/core/tafl_queue.sv
rtl/core/tafl_back.sv
rtl/core/tracker_adv_filter_table.sv
tb/sv/tracker_adv_filter_table_chk.sv
tb/sv/tracker_adv_filter_table_tb.sv
